// ===== hdl/rlm_pkg.sv =====
// shared types and constants of the rms level meter
`default_nettype none
package rlm_pkg;

	localparam int unsigned FRAMES_PER_BLOCK = 512;
	localparam int unsigned FPB_W            = 13;

	localparam int unsigned SUM_W   = 41;
	localparam int unsigned CNT_W   = 11;
	localparam int unsigned LVL_W   = 16;
	localparam int unsigned ROOT_W  = 22;
	localparam int unsigned RX_W    = 44;
	localparam int unsigned RREM_W  = 24;
	localparam int unsigned SCN_W   = 23;
	localparam int unsigned ITER_W  = 6;

	// quotient of the scaled level before clamping, and the reciprocal of 17
	// (floor(n * RECIP_17 >> RECIP_SHIFT) equals n / 17 for every n below 2^23)
	localparam int unsigned SCQ_W       = 19;
	localparam int unsigned RECIP_SHIFT = 27;
	localparam logic [SCN_W-1:0] RECIP_17 = 23'd7895161;

	localparam logic [CNT_W-1:0] COUNT_MAX = 11'd2047;
	localparam logic [SUM_W-1:0] SUM_MAX   = {SUM_W{1'b1}};

	localparam logic [15:0] KEEP_COEF  = 16'd60948;
	localparam logic [15:0] NEW_COEF   = 16'd4588;
	localparam logic [15:0] GAIN_RESET = 16'd4096;
	localparam logic [6:0]  SCALE_MUL  = 7'd100;

	localparam logic [ITER_W-1:0] DIV_STEPS  = 6'd41;
	localparam logic [ITER_W-1:0] ROOT_STEPS = 6'd22;

	localparam logic [1:0] REG_GAIN_ADDR = 2'd0;

	typedef struct packed {
		logic take;
		logic acc;
		logic div_step;
		logic root_load;
		logic root_step;
		logic sm_mul;
		logic sm_add;
		logic sc_load;
		logic sc_mul;
		logic out_load;
	} rlm_cmd_t;

	typedef struct packed {
		logic close;
		logic iter_last;
		logic out_busy;
	} rlm_status_t;

endpackage
`default_nettype wire

// ===== hdl/rms_level_meter_smoothed.sv =====
// top level of the block rms level meter with exponential smoothing
// usage:
//  - slave stream takes one stereo frame per beat: s_tdata holds the left
//    and right Q1.15 samples, s_tlast marks the final frame of an audio block
//  - a block also closes by itself once it holds FRAMES_PER_BLOCK frames
//  - master stream gives one beat per closed block: block rms, smoothed
//    level and scaled level, all unsigned Q0.16
//  - apb port holds the input gain (Q4.12, reset 4096 = unity) at address 0
//  - an ordinary frame passes through the accept cycle, in which the gain
//    is applied, and the accumulate cycle for the two squares
//  - a closing frame, from its beat to the result beat, goes through accept
//    and accumulate, a 41-step radix-2 divider for the mean, a load and 22
//    steps of the root unit, the smoothing multiply and add, /0.17 (times 100,
//    then times the reciprocal of 17), and the load of the output register
//  - the divider and root unit are iterative, one bit per cycle, and set
//    the cost of a block close
//  - the result waits in an output register; the next frames are accepted
//    while it waits, and only a further block close stalls on it
//  - reset empties the open block, clears the smoother, drops a waiting
//    result and sets the gain back to unity
`default_nettype none
module rms_level_meter_smoothed
	import rlm_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	// apb configuration port
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [1:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	// frame stream
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // left_sample [15:0], right_sample [31:16]
	input  wire logic        s_tlast,   // last_frame
	// level stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [47:0]      m_tdata    // block_rms [15:0], smoothed_level [31:16],
	                                    // scaled_level [47:32]
);

	logic [15:0] gain_q;
	rlm_cmd_t    cmd;
	rlm_status_t status;

	// apb: zero wait states, write completes in the access phase
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= GAIN_RESET;
		end else if (psel && penable && pwrite && pready && paddr == REG_GAIN_ADDR) begin
			gain_q <= pwdata[15:0];
		end
	end

	// reads of unmapped addresses return zero
	always_comb begin
		prdata = '0;
		if (paddr == REG_GAIN_ADDR) prdata = {16'd0, gain_q};
	end

	// sequencer: frame intake, block close and result handoff
	rlm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	// arithmetic and the output register
	rlm_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.status   (status),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.gain     (gain_q),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata)
	);

endmodule
`default_nettype wire

// ===== hdl/rlm_ctrl.sv =====
// sequencer of the rms level meter
`default_nettype none
module rlm_ctrl
	import rlm_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire rlm_status_t status,
	output rlm_cmd_t         cmd
);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_ACC   = 4'd1;
	localparam logic [3:0] ST_DIV   = 4'd2;
	localparam logic [3:0] ST_RLOAD = 4'd3;
	localparam logic [3:0] ST_ROOT  = 4'd4;
	localparam logic [3:0] ST_SMUL  = 4'd5;
	localparam logic [3:0] ST_SADD  = 4'd6;
	localparam logic [3:0] ST_SCL   = 4'd7;
	localparam logic [3:0] ST_RECIP = 4'd8;
	localparam logic [3:0] ST_OUT   = 4'd9;

	logic [3:0] state_q;
	logic [3:0] state_d;

	assign s_tready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.take = 1'b1;
					state_d  = ST_ACC;
				end
			end
			ST_ACC: begin
				cmd.acc = 1'b1;
				state_d = status.close ? ST_DIV : ST_IDLE;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (status.iter_last) state_d = ST_RLOAD;
			end
			ST_RLOAD: begin
				cmd.root_load = 1'b1;
				state_d       = ST_ROOT;
			end
			ST_ROOT: begin
				cmd.root_step = 1'b1;
				if (status.iter_last) state_d = ST_SMUL;
			end
			ST_SMUL: begin
				cmd.sm_mul = 1'b1;
				state_d    = ST_SADD;
			end
			ST_SADD: begin
				cmd.sm_add = 1'b1;
				state_d    = ST_SCL;
			end
			ST_SCL: begin
				cmd.sc_load = 1'b1;
				state_d     = ST_RECIP;
			end
			ST_RECIP: begin
				cmd.sc_mul = 1'b1;
				state_d    = ST_OUT;
			end
			ST_OUT: begin
				if (!status.out_busy) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// a frame beat is always followed by its accumulate cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q == ST_ACC))
		else $error("accumulate cycle missing after frame beat");

	// a frame that does not close the block returns straight to idle
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ACC && !status.close) |=> (state_q == ST_IDLE))
		else $error("open block did not return to idle");

	// a result handed to the output register frees the input again
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT && !status.out_busy) |=> (state_q == ST_IDLE))
		else $error("result handoff did not return to idle");

endmodule
`default_nettype wire

// ===== hdl/rlm_dp.sv =====
// datapath: gain, square sum, divider, square root, smoother, scaling, output register
`default_nettype none
module rlm_dp
	import rlm_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire rlm_cmd_t    cmd,
	output rlm_status_t      status,
	input  wire logic [31:0] s_tdata,
	input  wire logic        s_tlast,
	input  wire logic [15:0] gain,
	input  wire logic        m_tready,
	output logic             m_tvalid,
	output logic [47:0]      m_tdata
);

	function automatic logic signed [15:0] gain_sat(input logic signed [15:0] s,
		input logic [15:0] g);
		logic signed [32:0] p;
		logic signed [32:0] q;
		p = 33'(s) * 33'($signed({1'b0, g}));
		q = (p + 33'sd2048) >>> 12;
		if (q > 33'sd32767) begin
			gain_sat = 16'sh7FFF;
		end else if (q < -33'sd32768) begin
			gain_sat = 16'sh8000;
		end else begin
			gain_sat = q[15:0];
		end
	endfunction

	// captured frame
	logic signed [15:0] sl_q;
	logic signed [15:0] sr_q;
	logic               last_q;

	// block accumulators
	logic [SUM_W-1:0] sum_q;
	logic [CNT_W-1:0] cnt_q;
	logic [LVL_W-1:0] smoothed_q;

	// restoring divider for the mean
	logic [SUM_W-1:0]  dq_q;
	logic [CNT_W-1:0]  drem_q;
	logic [CNT_W-1:0]  dvs_q;
	logic [ITER_W-1:0] iter_q;

	// square root unit
	logic [RX_W-1:0]   rx_q;
	logic [RREM_W-1:0] rrem_q;
	logic [ROOT_W-1:0] root_q;

	// smoother pipeline
	logic [31:0]      prod_s1;
	logic [LVL_W-1:0] rms_s1;

	// scaling: times 100, then times the reciprocal of 17
	logic [SCN_W-1:0] sc_num_s1;
	logic [SCQ_W-1:0] sc_quo_s2;

	logic             mv_q;
	logic [47:0]      md_q;

	logic [31:0]      sq_l;
	logic [31:0]      sq_r;
	logic [SUM_W:0]   sum_wide;
	logic [SUM_W-1:0] sum_next;
	logic [CNT_W:0]   cnt_wide;
	logic [CNT_W-1:0] cnt_next;
	logic             close;

	logic [CNT_W:0]   trial;
	logic             d_ge;

	logic [RREM_W+1:0] rr;
	logic [RREM_W+1:0] rtrial;
	logic              r_ge;

	logic [LVL_W-1:0]   rms_sat;
	logic [32:0]        sm_sum;
	logic [LVL_W-1:0]   sm_sat;
	logic [SCN_W-1:0]   sc_num;
	logic [2*SCN_W-1:0] sc_prod;
	logic [LVL_W-1:0]   sc_sat;

	assign sq_l     = $unsigned(32'(sl_q) * 32'(sl_q));
	assign sq_r     = $unsigned(32'(sr_q) * 32'(sr_q));
	assign sum_wide = (SUM_W+1)'(sum_q) + (SUM_W+1)'(sq_l) + (SUM_W+1)'(sq_r);
	assign sum_next = (sum_wide > (SUM_W+1)'(SUM_MAX)) ? SUM_MAX : sum_wide[SUM_W-1:0];
	assign cnt_wide = (CNT_W+1)'(cnt_q) + (CNT_W+1)'(2);
	assign cnt_next = (cnt_wide > (CNT_W+1)'(COUNT_MAX)) ? COUNT_MAX : cnt_wide[CNT_W-1:0];
	assign close    = last_q || ((cnt_next < COUNT_MAX) &&
		(FPB_W'(cnt_next[CNT_W-1:1]) >= FPB_W'(FRAMES_PER_BLOCK)));

	assign trial = {drem_q, dq_q[SUM_W-1]};
	assign d_ge  = (trial >= {1'b0, dvs_q});

	assign rr     = {rrem_q, rx_q[RX_W-1 -: 2]};
	assign rtrial = {2'b00, root_q, 2'b01};
	assign r_ge   = (rr >= rtrial);

	assign rms_sat = (|root_q[ROOT_W-1:LVL_W]) ? {LVL_W{1'b1}} : root_q[LVL_W-1:0];
	assign sm_sum  = 33'(prod_s1) + 33'(32'(rms_s1) * 32'(NEW_COEF)) + 33'd32768;
	assign sm_sat  = sm_sum[32] ? {LVL_W{1'b1}} : sm_sum[31:16];
	assign sc_num  = SCN_W'(smoothed_q) * SCN_W'(SCALE_MUL) + SCN_W'(8);
	assign sc_prod = (2*SCN_W)'(sc_num_s1) * (2*SCN_W)'(RECIP_17);
	assign sc_sat  = (|sc_quo_s2[SCQ_W-1:LVL_W]) ? {LVL_W{1'b1}} : sc_quo_s2[LVL_W-1:0];

	assign status.close     = close;
	assign status.iter_last = (iter_q == ITER_W'(1));
	assign status.out_busy  = mv_q && !m_tready;

	assign m_tvalid = mv_q;
	assign m_tdata  = md_q;

	// frame capture, gain applied on the way in
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			sl_q   <= gain_sat(s_tdata[15:0], gain);
			sr_q   <= gain_sat(s_tdata[31:16], gain);
			last_q <= s_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q      <= '0;
			cnt_q      <= '0;
			smoothed_q <= '0;
			iter_q     <= '0;
			mv_q       <= 1'b0;
		end else begin
			if (cmd.acc) begin
				sum_q <= close ? '0 : sum_next;
				cnt_q <= close ? '0 : cnt_next;
				if (close) iter_q <= DIV_STEPS;
			end
			if (cmd.div_step || cmd.root_step) iter_q <= iter_q - ITER_W'(1);
			if (cmd.root_load) iter_q <= ROOT_STEPS;
			if (cmd.sm_add) smoothed_q <= sm_sat;
			if (cmd.out_load) begin
				mv_q <= 1'b1;
			end else if (m_tready) begin
				mv_q <= 1'b0;
			end
		end
	end

	// divider, root, smoother and scaling payload
	always_ff @(posedge clk) begin
		if (cmd.acc && close) begin
			dq_q   <= sum_next;
			drem_q <= '0;
			dvs_q  <= cnt_next;
		end else if (cmd.div_step) begin
			dq_q   <= {dq_q[SUM_W-2:0], d_ge};
			drem_q <= d_ge ? CNT_W'(trial - {1'b0, dvs_q}) : trial[CNT_W-1:0];
		end

		// radicand is four times the mean
		if (cmd.root_load) begin
			rx_q   <= {1'b0, dq_q, 2'b00};
			rrem_q <= '0;
			root_q <= '0;
		end else if (cmd.root_step) begin
			rx_q   <= {rx_q[RX_W-3:0], 2'b00};
			rrem_q <= r_ge ? RREM_W'(rr - rtrial) : rr[RREM_W-1:0];
			root_q <= {root_q[ROOT_W-2:0], r_ge};
		end

		if (cmd.sm_mul) begin
			prod_s1 <= 32'(smoothed_q) * 32'(KEEP_COEF);
			rms_s1  <= rms_sat;
		end

		if (cmd.sc_load) sc_num_s1 <= sc_num;
		if (cmd.sc_mul) sc_quo_s2 <= sc_prod[RECIP_SHIFT +: SCQ_W];

		if (cmd.out_load) md_q <= {sc_sat, smoothed_q, rms_s1};
	end

	// sample count stays even until it saturates
	assert property (@(posedge clk) disable iff (!arst_n)
		(!cnt_q[0] || cnt_q == COUNT_MAX))
		else $error("odd sample count below saturation");

	// a result is never written over a beat that is still waiting
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !(mv_q && !m_tready))
		else $error("pending result overwritten");

	// the published smoothed level is the stored smoother state
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(mv_q) |-> (md_q[31:16] == smoothed_q))
		else $error("smoothed level out of step with smoother state");

endmodule
`default_nettype wire

// ===== dv/rlm_level_checker.sv =====
// checker of the rms level meter: watches both streams and the apb port, predicts and compares
`timescale 1ns / 1ps
module rlm_level_checker
	import rlm_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic        pready,
	input  wire logic [1:0]  paddr,
	input  wire logic [31:0] pwdata,
	input  wire logic        s_tvalid,
	input  wire logic        s_tready,
	input  wire logic [31:0] s_tdata,   // left_sample [15:0], right_sample [31:16]
	input  wire logic        s_tlast,   // last_frame
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	input  wire logic [47:0] m_tdata,   // block_rms [15:0], smoothed_level [31:16],
	                                    // scaled_level [47:32]
	output int unsigned      error_count,
	output int unsigned      levels_pending,
	output int unsigned      frames_seen,
	output int unsigned      blocks_seen
);

	typedef struct packed {
		logic [15:0] scaled;
		logic [15:0] smoothed;
		logic [15:0] rms;
	} level_t;

	level_t expected_levels[$];

	logic [15:0]       gain_q412   = GAIN_RESET;
	longint unsigned   square_acc  = 0;
	int unsigned       sample_cnt  = 0;
	longint unsigned   smooth_lvl  = 0;
	int unsigned       mismatches  = 0;
	int unsigned       pending     = 0;
	int unsigned       frame_total = 0;
	int unsigned       block_total = 0;

	assign error_count    = mismatches;
	assign levels_pending = pending;
	assign frames_seen    = frame_total;
	assign blocks_seen    = block_total;

	task automatic report_mismatch(input string what, input longint unsigned got,
			input longint unsigned want);
		$display("[%0t] mismatch %s: got %0d, expected %0d", $realtime, what, got, want);
		mismatches++;
	endtask

	// gain, round half up, saturate to 16 bits
	function automatic longint scale_sample(input logic [15:0] raw);
		longint p;
		p = longint'($signed(raw)) * longint'(gain_q412);
		p = (p + 2048) >>> 12;
		if (p > 32767)
			p = 32767;
		else if (p < -32768)
			p = -32768;
		return p;
	endfunction

	function automatic longint unsigned int_sqrt(input longint unsigned v);
		longint unsigned res;
		longint unsigned probe;
		res   = 0;
		probe = 64'h4000_0000_0000_0000;
		while (probe > v)
			probe >>= 2;
		while (probe != 0) begin
			if (v >= res + probe) begin
				v   -= res + probe;
				res = (res >> 1) + probe;
			end else begin
				res >>= 1;
			end
			probe >>= 2;
		end
		return res;
	endfunction

	// one frame into the open block; returns 1 and the levels when the block closes
	function automatic logic accumulate_frame(input logic [15:0] l_raw, input logic [15:0] r_raw,
			input logic last, output level_t lv);
		longint          sl;
		longint          sr;
		longint unsigned mean;
		longint unsigned rms;
		longint unsigned sm;
		longint unsigned sc;
		logic            closing;
		sl = scale_sample(l_raw);
		sr = scale_sample(r_raw);
		square_acc += longint'(sl * sl + sr * sr);
		if (square_acc > longint'(SUM_MAX))
			square_acc = longint'(SUM_MAX);
		sample_cnt += 2;
		if (sample_cnt > int'(COUNT_MAX))
			sample_cnt = int'(COUNT_MAX);
		closing = last || (sample_cnt < int'(COUNT_MAX) && sample_cnt / 2 >= FRAMES_PER_BLOCK);
		lv = '0;
		if (!closing)
			return 1'b0;
		mean = square_acc / longint'(sample_cnt);
		rms  = int_sqrt(mean * 4);
		if (rms > 65535)
			rms = 65535;
		sm = (smooth_lvl * KEEP_COEF + rms * NEW_COEF + 32768) >> 16;
		if (sm > 65535)
			sm = 65535;
		smooth_lvl = sm;
		sc = (sm * 100 + 8) / 17;
		if (sc > 65535)
			sc = 65535;
		square_acc = 0;
		sample_cnt = 0;
		lv.rms      = rms[15:0];
		lv.smoothed = sm[15:0];
		lv.scaled   = sc[15:0];
		return 1'b1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		level_t got;
		level_t want;
		if (!arst_n) begin
			gain_q412  = GAIN_RESET;
			square_acc = 0;
			sample_cnt = 0;
			smooth_lvl = 0;
			expected_levels.delete();
		end else begin
			// result side first: an expectation never comes from the same edge
			if (m_tvalid && m_tready) begin
				got = m_tdata;
				if (expected_levels.size() == 0) begin
					report_mismatch("level beat with nothing expected", m_tdata, 0);
				end else begin
					want = expected_levels.pop_front();
					if (got.rms != want.rms)
						report_mismatch("block_rms", got.rms, want.rms);
					if (got.smoothed != want.smoothed)
						report_mismatch("smoothed_level", got.smoothed, want.smoothed);
					if (got.scaled != want.scaled)
						report_mismatch("scaled_level", got.scaled, want.scaled);
				end
			end
			if (s_tvalid && s_tready) begin
				frame_total++;
				if (accumulate_frame(s_tdata[15:0], s_tdata[31:16], s_tlast, want)) begin
					expected_levels = {expected_levels, want};
					block_total++;
				end
			end
			if (psel && penable && pwrite && pready && paddr == REG_GAIN_ADDR)
				gain_q412 = pwdata[15:0];
		end
		pending = expected_levels.size();
	end

endmodule

// ===== dv/tb.sv =====
// testbench top of the rms level meter: clock, reset, stimulus, flow control and verdict
`timescale 1ns / 1ps
module tb
	import rlm_pkg::*;
();

	localparam int FRAMES_PER_PHASE = 18;
	localparam int HOLD_CYCLES      = 400;   // long output hold, fills the result register
	localparam int SETTLE_CYCLES    = 120;   // quiet time after the last level has been taken
	localparam int STALL_LIMIT      = 5000;  // cycles without any beat before giving up

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        psel     = 1'b0;
	logic        penable  = 1'b0;
	logic        pwrite   = 1'b0;
	logic [1:0]  paddr    = '0;
	logic [31:0] pwdata   = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata  = '0;      // left_sample [15:0], right_sample [31:16]
	logic        s_tlast  = 1'b0;    // last_frame
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;            // block_rms [15:0], smoothed_level [31:16],
	                                 // scaled_level [47:32]

	int unsigned error_count;
	int unsigned levels_pending;
	int unsigned frames_seen;
	int unsigned blocks_seen;

	// flow control knobs, percent of cycles
	int tx_idle_pct  = 0;
	int rx_stall_pct = 0;

	// receiver hold-off request and its own counter
	logic hold_req   = 1'b0;
	logic hold_taken = 1'b0;
	int   hold_left  = 0;

	int   quiet_cycles = 0;

	always #2 clk = ~clk;

	rms_level_meter_smoothed i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	rlm_level_checker i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.pready         (pready),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.s_tlast        (s_tlast),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.error_count    (error_count),
		.levels_pending (levels_pending),
		.frames_seen    (frames_seen),
		.blocks_seen    (blocks_seen)
	);

	// receiver: random stalls, plus one long hold while the sender keeps going
	always @(posedge clk) begin
		if (hold_req && !hold_taken) begin
			hold_taken <= 1'b1;
			hold_left  <= HOLD_CYCLES;
			m_tready   <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready  <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
		end
	end

	// watchdog: any beat on either stream or a register access counts as progress
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
			$display("watchdog: no beat for %0d cycles, %0d levels still due",
				STALL_LIMIT, levels_pending);
			$display("DONE: errors detected");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// one apb write: setup cycle, then access cycle until pready
	task automatic write_gain(input logic [15:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= REG_GAIN_ADDR;
		pwdata  <= {16'h0000, value};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// one frame beat, with random idle cycles ahead of it
	task automatic send_frame(input logic [15:0] left, input logic [15:0] right,
			input logic last);
		while (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {right, left};
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
	endtask

	// stop offering, let every level come out, then give the datapath time to go quiet
	task automatic drain_levels();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (levels_pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// mix of full-scale extremes, full-range noise and quiet signal
	function automatic logic [15:0] draw_sample();
		case ($urandom_range(0, 5)) inside
			0: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
			[1:2]: return 16'($urandom);
			3: return 16'($signed($urandom_range(0, 255)) - 128);
			default: return 16'($signed($urandom_range(0, 8191)) - 4096);
		endcase
	endfunction

	initial begin
		int blk_len;
		int frames_sent;
		logic [15:0] phase_gain;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed frames at the reset gain (unity)
		send_frame(16'h7FFF, 16'h8000, 1'b1);       // both extremes in a one-frame block
		send_frame(16'h0000, 16'h0000, 1'b1);       // silent block
		// full negative scale squares to exactly 1.0, rms saturates;
		// repeated, it drives the smoother past the clamp of the scaled level
		repeat (5) send_frame(16'h8000, 16'h8000, 1'b1);
		send_frame(16'hFFFF, 16'h0001, 1'b0);       // multi-frame block
		send_frame(16'h5555, 16'hAAAA, 1'b0);
		send_frame(16'h0001, 16'hFFFF, 1'b1);
		drain_levels();

		// largest gain: scaled samples saturate both ways
		write_gain(16'hFFFF);
		send_frame(16'h0001, 16'hFFFF, 1'b0);
		send_frame(16'h7FFF, 16'h8000, 1'b1);
		send_frame(16'h0002, 16'hFFFD, 1'b1);
		drain_levels();

		// zero gain: every block measures silence
		write_gain(16'h0000);
		send_frame(16'h7FFF, 16'h8000, 1'b1);
		drain_levels();

		// random phases; idle pattern cycles through none, sender, receiver, both
		for (int phase = 0; phase < 6; phase++) begin
			case (phase % 4)
				0: begin tx_idle_pct = 0;  rx_stall_pct <= 0;  end
				1: begin tx_idle_pct = 74; rx_stall_pct <= 0;  end
				2: begin tx_idle_pct = 0;  rx_stall_pct <= 74; end
				default: begin tx_idle_pct = 37; rx_stall_pct <= 37; end
			endcase
			case (phase)
				0: phase_gain = GAIN_RESET;
				1: phase_gain = 16'hFFFF;
				2: phase_gain = 16'h0000;
				4: phase_gain = 16'($urandom_range(12000, 40000));
				default: phase_gain = 16'($urandom_range(0, 65535));
			endcase
			write_gain(phase_gain);
			// back-pressure: the receiver holds off while short blocks keep closing
			if (phase == 0)
				hold_req <= 1'b1;
			frames_sent = 0;
			while (frames_sent < FRAMES_PER_PHASE) begin
				if (phase != 0 && $urandom_range(0, 9) == 0)
					blk_len = $urandom_range(10, 40);
				else
					blk_len = $urandom_range(1, 6);
				for (int i = 0; i < blk_len; i++)
					send_frame(draw_sample(), draw_sample(), i == blk_len - 1);
				frames_sent += blk_len;
			end
			// one block with no last marker, closed by the frame count cap
			if (phase == 5) begin
				for (int i = 0; i < FRAMES_PER_BLOCK; i++)
					send_frame(draw_sample(), draw_sample(), 1'b0);
				send_frame(draw_sample(), draw_sample(), 1'b1);
			end
			drain_levels();
		end

		$display("covered %0d frames in %0d blocks, gains 0 to 65535, saturation, capped block",
			frames_seen, blocks_seen);
		$display("flow: free running, sender gaps, receiver stalls, both, %0d-cycle output hold",
			HOLD_CYCLES);
		if (error_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
